>>> hw/rtl/glw_pkg.sv
// Shared types and constants for the greedy line wrapper.
// Used by the channel interfaces, the step logic, the result buffer and the top level.
// No dependencies.
package glw_pkg;

  // Fixed field widths of the glyph and result beats.
  localparam int ADV_W     = 16;
  localparam int BRK_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Advance bits that take part in the width sums; higher bits are ignored.
  localparam int ADVANCE_BITS = 16;
  localparam logic [ADV_W-1:0] ADV_MASK =
    (ADVANCE_BITS >= ADV_W) ? {ADV_W{1'b1}} : ADV_W'((32'd1 << ADVANCE_BITS) - 32'd1);

  // Reset value of the row width limit.
  localparam logic [ADV_W-1:0] ROW_LIMIT_RST = {ADV_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LIMIT = 1'b0,
    CFG_WORD_MODE = 1'b1
  } cfg_reg_t;

  // One input glyph.
  typedef struct packed {
    logic [ADV_W-1:0] advance;
    logic             is_space;
    logic             line_start;
  } glyph_t;

  // One break result.
  typedef struct packed {
    logic [BRK_W-1:0] break_index;
    logic             drops_space;
    logic             error;
    logic             last;
  } result_t;

  // Results produced by one glyph: zero, one or two.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ADV_W-1:0] row_limit;
    logic             word_mode;
  } cfg_t;

endpackage

>>> hw/rtl/glw_in_if.sv
// Valid/ready channel that carries glyph beats into the line wrapper.
// Depends on glw_pkg for the field widths.
interface glw_in_if;
  import glw_pkg::*;

  logic             valid;
  logic             ready;
  logic [ADV_W-1:0] advance;
  logic             is_space;
  logic             line_start;

  modport source (output valid, output advance, output is_space, output line_start,
                  input ready);
  modport sink   (input valid, input advance, input is_space, input line_start,
                  output ready);
endinterface

>>> hw/rtl/glw_out_if.sv
// Valid/ready channel that carries break result beats out of the line wrapper.
// Depends on glw_pkg for the field widths.
interface glw_out_if;
  import glw_pkg::*;

  logic             valid;
  logic             ready;
  logic [BRK_W-1:0] break_index;
  logic             drops_space;
  logic             error;
  logic             last;

  modport source (output valid, output break_index, output drops_space, output error,
                  output last, input ready);
  modport sink   (input valid, input break_index, input drops_space, input error,
                  input last, output ready);
endinterface

>>> hw/rtl/glw_core.sv
// Row state and combinational break decision for one glyph.
// Depends on glw_pkg for the glyph, config and step types.
module glw_core #(
  parameter int MAX_LINE_GLYPHS = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  glw_pkg::glyph_t glyph,
  input  glw_pkg::cfg_t   cfg,
  output glw_pkg::step_t  step
);
  import glw_pkg::*;

  localparam int IDX_W = $clog2(MAX_LINE_GLYPHS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LINE_GLYPHS - 1);

  // Row state. Only whether the row holds any glyph matters, so the glyph
  // count is kept as a single busy flag.
  logic [ADV_W-1:0] row_width_r, row_width_nxt;
  logic [ADV_W-1:0] tail_width_r, tail_width_nxt;
  logic             space_valid_r, space_valid_nxt;
  logic [IDX_W-1:0] space_index_r, space_index_nxt;
  logic             row_busy_r, row_busy_nxt;
  logic [IDX_W-1:0] glyph_index_r, glyph_index_nxt;

  logic [ADV_W-1:0] adv;
  logic [ADV_W-1:0] base_row;
  logic [ADV_W-1:0] base_tail;
  logic             base_sv;
  logic [IDX_W-1:0] base_si;
  logic             base_busy;
  logic [IDX_W-1:0] idx;
  logic [ADV_W:0]   row_sum;
  logic [ADV_W:0]   tail_sum;
  logic [ADV_W:0]   limit;
  logic             space_here;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic result_t mk_res(input logic [IDX_W-1:0] i, input logic drop,
                                     input logic err, input logic fin);
    result_t r;
    r.break_index = BRK_W'(i);
    r.drops_space = drop;
    r.error       = err;
    r.last        = fin;
    return r;
  endfunction

  // A new logical line clears the row before the glyph is placed.
  always_comb begin
    adv = glyph.advance & ADV_MASK;
    if (glyph.line_start) begin
      base_row  = '0;
      base_tail = '0;
      base_sv   = 1'b0;
      base_si   = '0;
      base_busy = 1'b0;
      idx       = '0;
    end else begin
      base_row  = row_width_r;
      base_tail = tail_width_r;
      base_sv   = space_valid_r;
      base_si   = space_index_r;
      base_busy = row_busy_r;
      idx       = glyph_index_r;
    end
    row_sum    = {1'b0, base_row} + {1'b0, adv};
    tail_sum   = {1'b0, base_tail} + {1'b0, adv};
    limit      = {1'b0, cfg.row_limit};
    space_here = cfg.word_mode && glyph.is_space && base_busy;
  end

  // Break decision and next row state.
  always_comb begin
    row_width_nxt   = base_row;
    tail_width_nxt  = base_tail;
    space_valid_nxt = base_sv;
    space_index_nxt = base_si;
    row_busy_nxt    = base_busy;
    glyph_index_nxt = idx_inc(idx);
    step            = '0;

    priority if (adv > cfg.row_limit) begin
      // Glyph too wide for any row: report it, clear the row, skip the glyph.
      step.count      = 2'd1;
      step.first      = mk_res(idx, 1'b0, 1'b1, 1'b1);
      row_width_nxt   = '0;
      tail_width_nxt  = '0;
      space_valid_nxt = 1'b0;
      space_index_nxt = '0;
      row_busy_nxt    = 1'b0;
    end else if (row_sum <= limit) begin
      // The glyph fits; in word mode a space that is not first in the row is recorded.
      row_width_nxt = row_sum[ADV_W-1:0];
      if (space_here) begin
        space_valid_nxt = 1'b1;
        space_index_nxt = idx;
        tail_width_nxt  = '0;
      end else begin
        tail_width_nxt = tail_sum[ADV_W-1:0];
      end
      row_busy_nxt = 1'b1;
    end else if (space_here) begin
      // An overflowing space ends the row and is dropped.
      step.count      = 2'd1;
      step.first      = mk_res(idx_inc(idx), 1'b1, 1'b0, 1'b1);
      row_width_nxt   = '0;
      tail_width_nxt  = '0;
      space_valid_nxt = 1'b0;
      space_index_nxt = '0;
      row_busy_nxt    = 1'b0;
    end else if (cfg.word_mode && base_sv) begin
      // Word break after the recorded space; the tail may still overflow.
      space_valid_nxt = 1'b0;
      space_index_nxt = '0;
      tail_width_nxt  = '0;
      row_busy_nxt    = 1'b1;
      if (tail_sum > limit) begin
        step.count    = 2'd2;
        step.first    = mk_res(idx_inc(base_si), 1'b1, 1'b0, 1'b0);
        step.second   = mk_res(idx, 1'b0, 1'b0, 1'b1);
        row_width_nxt = adv;
      end else begin
        step.count    = 2'd1;
        step.first    = mk_res(idx_inc(base_si), 1'b1, 1'b0, 1'b1);
        row_width_nxt = tail_sum[ADV_W-1:0];
      end
    end else begin
      // Plain break at the glyph, which starts the new row.
      step.count      = 2'd1;
      step.first      = mk_res(idx, 1'b0, 1'b0, 1'b1);
      row_width_nxt   = adv;
      tail_width_nxt  = '0;
      space_valid_nxt = 1'b0;
      space_index_nxt = '0;
      row_busy_nxt    = 1'b1;
    end
  end

  // State registers advance once per glyph leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= '0;
      tail_width_r  <= '0;
      space_valid_r <= 1'b0;
      space_index_r <= '0;
      row_busy_r    <= 1'b0;
      glyph_index_r <= '0;
    end else if (fire) begin
      row_width_r   <= row_width_nxt;
      tail_width_r  <= tail_width_nxt;
      space_valid_r <= space_valid_nxt;
      space_index_r <= space_index_nxt;
      row_busy_r    <= row_busy_nxt;
      glyph_index_r <= glyph_index_nxt;
    end
  end

endmodule

>>> hw/rtl/glw_rbuf.sv
// Two-entry result register that drains one break beat per cycle while out_ready is high.
// Depends on glw_pkg for the step and result types.
module glw_rbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  glw_pkg::step_t   step,
  input  logic            out_ready,
  output logic            free,
  output logic            out_valid,
  output glw_pkg::result_t out_res
);
  import glw_pkg::*;

  logic [1:0] count_r, count_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_res   = head_r;
  assign pop       = out_valid && out_ready;
  // Empty after this cycle's beat leaves, so a new load may land.
  assign free      = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);

  // Load replaces the contents; otherwise a taken beat shifts the queue.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (load) begin
      count_nxt = step.count;
      head_nxt  = step.first;
      tail_nxt  = step.second;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
      head_nxt  = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> hw/rtl/greedy_line_wrap.sv
// Greedy line wrapper: turns a glyph stream into visual row break events.
// Glyph beats enter on in_ch, break beats leave on out_ch. A glyph that fits
// its row gives no beat; an overflow gives one beat, or two when the text
// after the last space is itself too wide; a glyph wider than the row limit
// gives one beat with error set. The final beat of a glyph has last set.
// A glyph accepted on in_ch is decided from the input register; its break
// beats are loaded into the result register and offered on out_ch from it.
// Throughput: one glyph per cycle while out_ch takes the beats. The result
// register holds both beats of a glyph and drains one beat per cycle while
// out_ch.ready is high, so after a glyph with two beats the next glyph that breaks
// waits in the input register until one beat is left. A stall on out_ch fills the
// result register, then the input register, then in_ch.ready drops; no beat is lost.
// Reset (rst_n low at a clock edge) empties both registers, clears the row and
// glyph index, and sets the row limit to all ones and word_mode to zero.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge and must only be issued while no glyph is in flight.
// Depends on glw_pkg, glw_in_if, glw_out_if, glw_core and glw_rbuf.
module greedy_line_wrap #(
  parameter int MAX_LINE_GLYPHS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  glw_in_if.sink                          in_ch,
  glw_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [glw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glw_pkg::ADV_W-1:0]       cfg_data
);
  import glw_pkg::*;

  cfg_t    cfg_r;
  logic    in_v_r;
  glyph_t  in_g_r;
  step_t   step;
  logic    buf_free;
  logic    adv_go;
  logic    load;
  result_t out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_limit <= ROW_LIMIT_RST;
      cfg_r.word_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROW_LIMIT: cfg_r.row_limit <= cfg_data;
        CFG_WORD_MODE: cfg_r.word_mode <= cfg_data[0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // The glyph leaves the input register when its beats fit in the result register.
  assign adv_go      = in_v_r && ((step.count == 2'd0) || buf_free);
  assign load        = adv_go && (step.count != 2'd0);
  assign in_ch.ready = !in_v_r || adv_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (adv_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_g_r.advance    <= in_ch.advance;
      in_g_r.is_space   <= in_ch.is_space;
      in_g_r.line_start <= in_ch.line_start;
    end
  end

  glw_core #(
    .MAX_LINE_GLYPHS(MAX_LINE_GLYPHS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv_go),
    .glyph (in_g_r),
    .cfg   (cfg_r),
    .step  (step)
  );

  glw_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .step      (step),
    .out_ready (out_ch.ready),
    .free      (buf_free),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.break_index = out_res.break_index;
  assign out_ch.drops_space = out_res.drops_space;
  assign out_ch.error       = out_res.error;
  assign out_ch.last        = out_res.last;

  // An error beat is always the only beat of its glyph.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.last && !out_ch.drops_space)
    else $error("error beat without last or with a dropped space");

  // With two beats, only the second closes the glyph.
  a_two_beats: assert property (@(posedge clk) disable iff (!rst_n)
    adv_go && (step.count == 2'd2) |-> !step.first.last && step.second.last)
    else $error("two-beat glyph with wrong last marks");

  // A decided glyph with beats is offered on the output at the next cycle.
  a_offer: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid)
    else $error("loaded break beat not offered");

  // Beats never exceed two per glyph.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> step.count != 2'd3)
    else $error("more than two beats for one glyph");

endmodule
